// ===== design/qre_pkg.sv =====
// ----------------------------------------------------------------------------
// qre_pkg
// Shared types and constants of the quaternion rotation engine.
// ----------------------------------------------------------------------------
`default_nettype none

package qre_pkg;

    localparam int QUAT_WIDTH      = 16;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int CFG_INDEX_WIDTH = 3;
    // Fraction bits of an exact quaternion product
    localparam int QPROD_FRAC      = 28;

    localparam logic [1:0] REBUILD_CYCLES = 2'd2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_QUAT_W     = 3'd0,
        REG_QUAT_X     = 3'd1,
        REG_QUAT_Y     = 3'd2,
        REG_QUAT_Z     = 3'd3,
        REG_CONVENTION = 3'd4
    } cfg_reg_t;

    typedef logic signed [QUAT_WIDTH-1:0] quat_t;

    typedef struct packed {
        quat_t w;
        quat_t x;
        quat_t y;
        quat_t z;
        logic  conv;
    } quat_cfg_t;

endpackage

`default_nettype wire

// ===== design/qre_coef.sv =====
// ----------------------------------------------------------------------------
// qre_coef
// Two-stage matrix builder: quaternion products, then entry sums, rounding
// and saturation to the coefficient format.
// ----------------------------------------------------------------------------
`default_nettype none

module qre_coef import qre_pkg::*; #(
    parameter int COEF_FRAC = 14
) (
    input  wire logic                       aclk,
    input  wire quat_cfg_t                  cfg,
    output logic      [8:0][COEF_FRAC+1:0]  coef
);

    localparam int CW  = COEF_FRAC + 2;
    localparam int PW  = 2 * QUAT_WIDTH;
    localparam int QW  = PW + 7;
    localparam int RSH = (COEF_FRAC < QPROD_FRAC) ? QPROD_FRAC - COEF_FRAC : 0;
    localparam int LSH = (COEF_FRAC > QPROD_FRAC) ? COEF_FRAC - QPROD_FRAC : 0;

    localparam logic signed [QW-1:0] ONE  = QW'(1) << QPROD_FRAC;
    localparam logic signed [QW-1:0] HALF = QW'((64'(1) << RSH) >> 1);
    localparam logic signed [QW-1:0] CMAX = (QW'(1) << (CW - 1)) - QW'(1);
    localparam logic signed [QW-1:0] CMIN = -CMAX - QW'(1);

    logic signed [PW-1:0] pxx_reg, pyy_reg, pzz_reg;
    logic signed [PW-1:0] pxy_reg, pxz_reg, pyz_reg;
    logic signed [PW-1:0] pwx_reg, pwy_reg, pwz_reg;
    logic                 conv_reg;

    logic signed [QW-1:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [QW-1:0] ent [9];
    logic signed [QW-1:0] src [9];
    logic signed [QW-1:0] scl [9];
    logic [8:0][CW-1:0]   coef_next;
    logic [8:0][CW-1:0]   coef_reg;

    always_ff @(posedge aclk) begin
        pxx_reg  <= $signed(cfg.x) * $signed(cfg.x);
        pyy_reg  <= $signed(cfg.y) * $signed(cfg.y);
        pzz_reg  <= $signed(cfg.z) * $signed(cfg.z);
        pxy_reg  <= $signed(cfg.x) * $signed(cfg.y);
        pxz_reg  <= $signed(cfg.x) * $signed(cfg.z);
        pyz_reg  <= $signed(cfg.y) * $signed(cfg.z);
        pwx_reg  <= $signed(cfg.w) * $signed(cfg.x);
        pwy_reg  <= $signed(cfg.w) * $signed(cfg.y);
        pwz_reg  <= $signed(cfg.w) * $signed(cfg.z);
        conv_reg <= cfg.conv;
    end

    always_comb begin
        xx = QW'(pxx_reg);
        yy = QW'(pyy_reg);
        zz = QW'(pzz_reg);
        xy = QW'(pxy_reg);
        xz = QW'(pxz_reg);
        yz = QW'(pyz_reg);
        wx = QW'(pwx_reg);
        wy = QW'(pwy_reg);
        wz = QW'(pwz_reg);

        // inertial-to-object matrix, row major, Q.28
        ent[0] = ONE - ((yy + zz) <<< 1);
        ent[1] = (xy + wz) <<< 1;
        ent[2] = (xz - wy) <<< 1;
        ent[3] = (xy - wz) <<< 1;
        ent[4] = ONE - ((xx + zz) <<< 1);
        ent[5] = (yz + wx) <<< 1;
        ent[6] = (xz + wy) <<< 1;
        ent[7] = (yz - wx) <<< 1;
        ent[8] = ONE - ((xx + yy) <<< 1);

        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                src[r*3+c] = conv_reg ? ent[c*3+r] : ent[r*3+c];
            end
        end

        for (int k = 0; k < 9; k++) begin
            scl[k] = ((src[k] + HALF) >>> RSH) <<< LSH;
            if (scl[k] > CMAX) begin
                coef_next[k] = CMAX[CW-1:0];
            end else if (scl[k] < CMIN) begin
                coef_next[k] = CMIN[CW-1:0];
            end else begin
                coef_next[k] = scl[k][CW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        coef_reg <= coef_next;
    end

    assign coef = coef_reg;

endmodule

`default_nettype wire

// ===== design/qre_lane.sv =====
// ----------------------------------------------------------------------------
// qre_lane
// One output component: three coefficient products, sum with round half up,
// shift and saturation. Three register stages, advanced by en.
// ----------------------------------------------------------------------------
`default_nettype none

module qre_lane import qre_pkg::*; #(
    parameter int VEC_WIDTH = 32,
    parameter int COEF_FRAC = 14
) (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic signed [VEC_WIDTH-1:0]   vec  [3],
    input  wire logic signed [COEF_FRAC+1:0]   coef [3],
    output logic signed      [VEC_WIDTH-1:0]   res,
    output logic                               sat
);

    localparam int CW    = COEF_FRAC + 2;
    localparam int HI_W  = (VEC_WIDTH > COEF_FRAC) ? VEC_WIDTH - COEF_FRAC : 1;
    localparam int EXT_W = ((VEC_WIDTH > COEF_FRAC) ? VEC_WIDTH : COEF_FRAC) + 1;
    localparam int HP_W  = HI_W + CW;
    localparam int LP_W  = COEF_FRAC + 1 + CW;
    localparam int HS_W  = HP_W + 2;
    localparam int LS_W  = LP_W + 2;
    localparam int LSH_W = LS_W - COEF_FRAC;
    localparam int RW    = ((HS_W > LSH_W) ? HS_W : LSH_W) + 1;

    localparam logic signed [LS_W-1:0] LS_HALF = LS_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [RW-1:0]   VMAX    = (RW'(1) << (VEC_WIDTH - 1)) - RW'(1);
    localparam logic signed [RW-1:0]   VMIN    = -VMAX - RW'(1);

    logic signed [EXT_W-1:0]     ext  [3];
    logic signed [EXT_W-1:0]     eshr [3];
    logic signed [HI_W-1:0]      vhi  [3];
    logic signed [COEF_FRAC:0]   vlo  [3];

    logic signed [HP_W-1:0] hp_next [3];
    logic signed [HP_W-1:0] hp_reg  [3];
    logic signed [LP_W-1:0] lp_next [3];
    logic signed [LP_W-1:0] lp_reg  [3];

    logic signed [HS_W-1:0] hs_next, hs_reg;
    logic signed [LS_W-1:0] ls_next, ls_reg;

    logic signed [LS_W-1:0]      lsh;
    logic signed [RW-1:0]        sum;
    logic signed [VEC_WIDTH-1:0] res_next, res_reg;
    logic                        sat_next, sat_reg;

    // Split each component into a signed high part and an unsigned low part
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            ext[j]     = EXT_W'(vec[j]);
            eshr[j]    = ext[j] >>> COEF_FRAC;
            vhi[j]     = eshr[j][HI_W-1:0];
            vlo[j]     = {1'b0, ext[j][COEF_FRAC-1:0]};
            hp_next[j] = vhi[j] * coef[j];
            lp_next[j] = vlo[j] * coef[j];
        end
    end

    always_comb begin
        hs_next = HS_W'(hp_reg[0]) + HS_W'(hp_reg[1]) + HS_W'(hp_reg[2]);
        ls_next = LS_W'(lp_reg[0]) + LS_W'(lp_reg[1]) + LS_W'(lp_reg[2]) + LS_HALF;
    end

    always_comb begin
        lsh = ls_reg >>> COEF_FRAC;
        sum = RW'(hs_reg) + RW'(lsh);
        if (sum > VMAX) begin
            res_next = VMAX[VEC_WIDTH-1:0];
            sat_next = 1'b1;
        end else if (sum < VMIN) begin
            res_next = VMIN[VEC_WIDTH-1:0];
            sat_next = 1'b1;
        end else begin
            res_next = sum[VEC_WIDTH-1:0];
            sat_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hp_reg  <= hp_next;
            lp_reg  <= lp_next;
            hs_reg  <= hs_next;
            ls_reg  <= ls_next;
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign res = res_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

// ===== design/qre_merge.sv =====
// ----------------------------------------------------------------------------
// qre_merge
// Joins the three lane results into one result request, merges the clip
// flags, and holds the output register with a skid stage behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module qre_merge import qre_pkg::*; #(
    parameter int VEC_WIDTH   = 32,
    parameter int TDATA_WIDTH = 96
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          pipe_valid,
    output logic                               pipe_ready,
    input  wire logic signed [VEC_WIDTH-1:0]   res [3],
    input  wire logic        [2:0]             sat,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic             [TDATA_WIDTH-1:0] m_tdata,
    output logic                               m_tuser
);

    logic [TDATA_WIDTH-1:0] pipe_data;
    logic                   pipe_flag;
    logic                   pipe_fire;

    logic                   out_valid_reg, out_valid_next;
    logic [TDATA_WIDTH-1:0] out_data_reg,  out_data_next;
    logic                   out_flag_reg,  out_flag_next;
    logic                   skid_valid_reg, skid_valid_next;
    logic [TDATA_WIDTH-1:0] skid_data_reg,  skid_data_next;
    logic                   skid_flag_reg,  skid_flag_next;

    assign pipe_data  = TDATA_WIDTH'({res[2], res[1], res[0]});
    assign pipe_flag  = |sat;
    assign pipe_ready = !skid_valid_reg;
    assign pipe_fire  = pipe_valid && pipe_ready;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_flag_next   = out_flag_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_flag_next  = skid_flag_reg;

        if (m_tready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                // drain the skid stage first
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                out_flag_next   = skid_flag_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = pipe_fire;
                out_data_next  = pipe_data;
                out_flag_next  = pipe_flag;
            end
        end else if (pipe_fire) begin
            // output stalled: park the request
            skid_valid_next = 1'b1;
            skid_data_next  = pipe_data;
            skid_flag_next  = pipe_flag;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        out_flag_reg  <= out_flag_next;
        skid_data_reg <= skid_data_next;
        skid_flag_reg <= skid_flag_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_flag_reg;

endmodule

`default_nettype wire

// ===== design/quaternion_rotation_engine_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_rotation_engine_unit
// Rotates one 3-component vector per clock, while s_tready is high, by a
// 3x3 matrix built from a Q1.14 quaternion held in configuration registers.
// Each input request is multiplied by the matrix (tuser 1) or its transpose
// (tuser 0); every component is rounded half up, shifted right by COEF_FRAC
// and saturated, and the result tuser flags any clip. Three lanes, one per
// output component, run in parallel, so one request is taken every cycle
// unless a rebuild runs or the skid stage is full; the skid stage parks one
// request while the output is stalled. Every write to a defined register,
// and reset, starts a matrix rebuild in the two-stage coefficient unit;
// s_tready stays low while it runs. After reset the matrix is identity.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotation_engine_unit import qre_pkg::*; #(
    parameter int VEC_WIDTH = 32,
    parameter int COEF_FRAC = 14
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // configuration write port
    input  wire logic                                  cfg_wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0]            cfg_wr_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]             cfg_wr_data,
    // input stream
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    input  wire logic [((3*VEC_WIDTH+7)/8)*8-1:0]      s_tdata,  // vec_x, vec_y, vec_z
    input  wire logic                                  s_tuser,  // kind
    // result stream
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    output logic      [((3*VEC_WIDTH+7)/8)*8-1:0]      m_tdata,  // out_x, out_y, out_z
    output logic                                       m_tuser   // saturated
);

    localparam int TDATA_WIDTH = ((3 * VEC_WIDTH + 7) / 8) * 8;
    localparam int CW          = COEF_FRAC + 2;

    quat_cfg_t  cfg_reg, cfg_next;
    logic       cfg_hit;
    logic [1:0] busy_reg, busy_next;

    logic [8:0][CW-1:0]          mat;
    logic signed [CW-1:0]        lane_coef [3][3];

    logic                        pipe_ready;
    logic                        s_fire;
    logic [3:0]                  vld_reg, vld_next;
    logic signed [VEC_WIDTH-1:0] vec_reg [3];
    logic                        kind_reg;

    logic signed [VEC_WIDTH-1:0] lane_res [3];
    logic [2:0]                  lane_sat;

    // Configuration registers
    always_comb begin
        cfg_next = cfg_reg;
        cfg_hit  = 1'b0;
        if (cfg_wr_en) begin
            cfg_hit = 1'b1;
            case (cfg_reg_t'(cfg_wr_index))
                REG_QUAT_W:     cfg_next.w    = cfg_wr_data;
                REG_QUAT_X:     cfg_next.x    = cfg_wr_data;
                REG_QUAT_Y:     cfg_next.y    = cfg_wr_data;
                REG_QUAT_Z:     cfg_next.z    = cfg_wr_data;
                REG_CONVENTION: cfg_next.conv = cfg_wr_data[0];
                default:        cfg_hit       = 1'b0;
            endcase
        end
    end

    always_comb begin
        if (cfg_hit) begin
            busy_next = REBUILD_CYCLES;
        end else if (busy_reg != 2'd0) begin
            busy_next = busy_reg - 2'd1;
        end else begin
            busy_next = busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.w    <= quat_t'(16'sd16384);
            cfg_reg.x    <= '0;
            cfg_reg.y    <= '0;
            cfg_reg.z    <= '0;
            cfg_reg.conv <= 1'b0;
            busy_reg     <= REBUILD_CYCLES;
        end else begin
            cfg_reg      <= cfg_next;
            busy_reg     <= busy_next;
        end
    end

    qre_coef #(
        .COEF_FRAC (COEF_FRAC)
    ) u_coef (
        .aclk (aclk),
        .cfg  (cfg_reg),
        .coef (mat)
    );

    // Input stage
    assign s_tready = pipe_ready && (busy_reg == 2'd0);
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        vld_next = pipe_ready ? {vld_reg[2:0], s_fire} : vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_ready) begin
            for (int j = 0; j < 3; j++) begin
                vec_reg[j] <= s_tdata[j*VEC_WIDTH +: VEC_WIDTH];
            end
            kind_reg <= s_tuser;
        end
    end

    // Row i of the matrix, or column i for the transpose
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                lane_coef[i][j] = kind_reg ? $signed(mat[i*3+j]) : $signed(mat[j*3+i]);
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        qre_lane #(
            .VEC_WIDTH (VEC_WIDTH),
            .COEF_FRAC (COEF_FRAC)
        ) u_lane (
            .aclk (aclk),
            .en   (pipe_ready),
            .vec  (vec_reg),
            .coef (lane_coef[g]),
            .res  (lane_res[g]),
            .sat  (lane_sat[g])
        );
    end

    qre_merge #(
        .VEC_WIDTH   (VEC_WIDTH),
        .TDATA_WIDTH (TDATA_WIDTH)
    ) u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_valid (vld_reg[3]),
        .pipe_ready (pipe_ready),
        .res        (lane_res),
        .sat        (lane_sat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire
